[src/etbs_pkg.sv]
// Shared constants, types and helpers for the extent table binary search block.
`default_nettype none

package etbs_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int DATA_W      = 32;
    localparam int SLOTNUM_W   = 8;
    localparam int MATCH_W     = 9;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    // Item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // One table entry as held in the memory
    typedef struct packed {
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] logical;
        logic [DATA_W-1:0] length;
    } entry_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_EDGE_SRCH = 7'b0000100,
        ST_EDGE_CHK  = 7'b0001000,
        ST_HIT_SRCH  = 7'b0010000,
        ST_HIT_CHK   = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    // Midpoint of a search window, rounded down
    function automatic logic [SLOT_W-1:0] midpoint(input logic [SLOT_W-1:0] lo,
                                                   input logic [SLOT_W-1:0] hi);
        logic [SLOT_W-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

    // Extent covers target: logical <= target < logical + length, no wrap
    function automatic logic covers(input entry_t e, input logic [DATA_W-1:0] target);
        logic [DATA_W:0] lo_ext;
        logic [DATA_W:0] hi_ext;
        logic [DATA_W:0] tg_ext;
        lo_ext = {1'b0, e.logical};
        hi_ext = lo_ext + {1'b0, e.length};
        tg_ext = {1'b0, target};
        return (tg_ext >= lo_ext) && (tg_ext < hi_ext);
    endfunction

endpackage

`default_nettype wire

[src/extent_table_binary_search.sv]
// Extent table with two-phase binary search over one synchronous table memory.
// A write item is written to the table from the idle state; a search item runs the boundary
//   search, then the hit search unless the table is empty, and then the done state.
// Throughput: one item at a time; each halving step makes one memory probe, so the
//   one-read-per-cycle table memory sets the search time.
// Reset: the table is cleared by a pass of TABLE_SLOTS cycles after reset, in_stall high.
`default_nettype none

module extent_table_binary_search
    import etbs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [SLOTNUM_W-1:0] slot_number,
    input  wire logic [DATA_W-1:0]    phys_start,
    input  wire logic [DATA_W-1:0]    first_file_block,
    input  wire logic [DATA_W-1:0]    extent_length,
    input  wire logic [DATA_W-1:0]    target_block,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [MATCH_W-1:0]        match_slot
);

    // Table memory and its registered read port
    entry_t            table_mem [TABLE_SLOTS];
    entry_t            rdata_reg;

    // Control state
    state_t            state_reg,     state_next;
    logic [SLOT_W-1:0] clr_reg,       clr_next;
    logic              out_valid_reg, out_valid_next;

    // Search datapath
    logic [SLOT_W-1:0]  lo_reg,     lo_next;
    logic [SLOT_W-1:0]  hi_reg,     hi_next;
    logic [SLOT_W-1:0]  mid_reg,    mid_next;
    logic [CNT_W-1:0]   edge_reg,   edge_next;
    logic [CNT_W-1:0]   result_reg, result_next;
    logic [DATA_W-1:0]  target_reg, target_next;
    logic [MATCH_W-1:0] match_reg,  match_next;

    // Memory port controls
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;

    // Helpers
    logic                      in_accept;
    logic                      go_low;
    logic [SLOT_W-1:0]         step_lo;
    logic [SLOT_W-1:0]         step_hi;
    logic [CNT_W-1:0]          edge_calc;
    logic [CNT_W-1:0]          hi_calc;
    logic [SLOT_W+SLOTNUM_W-1:0] slot_wide;
    logic [CNT_W+MATCH_W-1:0]  result_wide;
    logic                      hit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign match_slot = match_reg;

    assign slot_wide   = {{SLOT_W{1'b0}}, slot_number};
    assign result_wide = {{MATCH_W{1'b0}}, result_reg};
    assign hit         = covers(rdata_reg, target_reg);

    // One halving step on the entry read for mid
    always_comb
    begin
        if (state_reg == ST_EDGE_SRCH)
        begin
            go_low = (rdata_reg.phys == '0);
        end
        else
        begin
            go_low = (target_reg < rdata_reg.logical);
        end
        step_lo = go_low ? lo_reg : (mid_reg + SLOT_W'(1));
        step_hi = go_low ? mid_reg : hi_reg;
    end

    // Boundary from the final edge probe
    always_comb
    begin
        if (rdata_reg.phys == '0)
        begin
            edge_calc = {1'b0, hi_reg};
        end
        else
        begin
            edge_calc = {1'b0, hi_reg} + CNT_W'(1);
        end
        hi_calc = edge_calc - CNT_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        edge_next      = edge_reg;
        result_next    = result_reg;
        target_next    = target_reg;
        match_next     = match_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = '0;
        rd_addr        = mid_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + SLOT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        wr_addr = slot_wide[SLOT_W-1:0];
                        wr_data.phys    = phys_start;
                        wr_data.logical = first_file_block;
                        wr_data.length  = extent_length;
                        wr_en = ({{CNT_W{1'b0}}, slot_number} <
                                 (CNT_W + SLOTNUM_W)'(TABLE_SLOTS));
                    end
                    else
                    begin
                        target_next = target_block;
                        lo_next     = '0;
                        hi_next     = LAST_SLOT;
                        mid_next    = midpoint('0, LAST_SLOT);
                        rd_addr     = mid_next;
                        state_next  = ST_EDGE_SRCH;
                    end
                end
            end

            ST_EDGE_SRCH, ST_HIT_SRCH:
            begin
                if ((state_reg == ST_HIT_SRCH) && hit)
                begin
                    result_next = {1'b0, mid_reg};
                    state_next  = ST_DONE;
                end
                else
                begin
                    lo_next = step_lo;
                    hi_next = step_hi;
                    if (step_lo < step_hi)
                    begin
                        mid_next = midpoint(step_lo, step_hi);
                        rd_addr  = mid_next;
                    end
                    else
                    begin
                        rd_addr    = step_hi;
                        state_next = (state_reg == ST_EDGE_SRCH) ? ST_EDGE_CHK : ST_HIT_CHK;
                    end
                end
            end

            ST_EDGE_CHK:
            begin
                edge_next = edge_calc;
                if (edge_calc == '0)
                begin
                    // empty table
                    result_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = hi_calc[SLOT_W-1:0];
                    if (hi_calc[SLOT_W-1:0] != '0)
                    begin
                        mid_next   = midpoint('0, hi_calc[SLOT_W-1:0]);
                        rd_addr    = mid_next;
                        state_next = ST_HIT_SRCH;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        state_next = ST_HIT_CHK;
                    end
                end
            end

            ST_HIT_CHK:
            begin
                result_next = hit ? {1'b0, hi_reg} : edge_reg;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    match_next     = result_wide[MATCH_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= table_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        edge_reg   <= edge_next;
        result_reg <= result_next;
        target_reg <= target_next;
        match_reg  <= match_next;
    end

    // A search item always starts the boundary search
    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (cmd == CMD_SEARCH)) |=> (state_reg == ST_EDGE_SRCH))
        else $error("search item did not start boundary search");

    // A write item never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (cmd == CMD_WRITE) && !out_valid_reg) |=> !out_valid_reg)
        else $error("write item produced a result");

    // Probe index stays inside the open search window
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EDGE_SRCH) || (state_reg == ST_HIT_SRCH))
        |-> ((mid_reg >= lo_reg) && (mid_reg < hi_reg)))
        else $error("probe outside search window");

    // A new result comes only from the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

endmodule

`default_nettype wire
